>>> design/ufr_pkg.sv
// Shared types and constants for the UART frame receiver.
package ufr_pkg;

    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    localparam logic [7:0] HEADER_CHAR  = 8'h23;
    localparam logic [7:0] TRAILER_CHAR = 8'h24;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       frame_ready;
        logic [7:0] frame_length;
        logic [7:0] read_byte;
    } t_result;

endpackage

>>> design/uart_frame_receiver.sv
// UART frame receiver top level: parser front end, result queue, output stage.
// Input channel: i_valid / o_stall with i_mode, i_rx_byte, i_read_index. Mode byte
//   feeds the frame parser ('#', length, payload, '$', checksum), mode release
//   clears the held frame, mode read returns one stored byte.
// Output channel: o_valid / i_stall with o_frame_ready, o_frame_length and
//   o_read_byte; exactly one result transaction per input transaction, in order.
// Throughput: one transaction per cycle while o_stall is low; the parser phase update
//   is registered on accept; the frame store has one write and one read port.
// Result path: an accepted input passes through the parser/store-read stage,
//   the queue and the output register before its result is presented.
// Reset: synchronous, active low; parser returns to header hunt, length reads
//   as 0, queue and output stage empty. Frame store contents are not cleared,
//   no clearing pass is needed.
// Downstream stall: the output register holds its transaction, the queue fills,
//   and o_stall rises only once the queue is full and the front stage is
//   occupied; no transaction is dropped.
module uart_frame_receiver #(
    parameter int STORE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_read_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_frame_ready,
    output logic [7:0] o_frame_length,
    output logic [7:0] o_read_byte
);
    import ufr_pkg::*;

    logic    q_full;
    logic    q_push;
    t_result q_in;
    logic    q_pop;
    logic    q_valid;
    t_result q_out;

    ufr_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_rx_byte    (i_rx_byte),
        .i_read_index (i_read_index),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_in)
    );

    ufr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    ufr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_out),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_ready  (o_frame_ready),
        .o_frame_length (o_frame_length),
        .o_read_byte    (o_read_byte)
    );

endmodule

>>> design/ufr_front.sv
// Front end: accepts transactions, runs the frame parser and frame store, feeds the queue.
module ufr_front #(
    parameter int STORE_DEPTH = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_mode,
    input  logic [7:0]      i_rx_byte,
    input  logic [7:0]      i_read_index,
    input  logic            i_q_full,
    output logic            o_q_push,
    output ufr_pkg::t_result o_q_data
);
    import ufr_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        HUNT    = 3'd0,
        LEN     = 3'd1,
        PAYLOAD = 3'd2,
        TRAILER = 3'd3,
        CHECK   = 3'd4,
        HELD    = 3'd5
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_count, n_count;
    logic       r_ready, n_ready;
    logic [7:0] r_length, n_length;

    logic       r_s1_valid;
    logic       r_s1_ready;
    logic [7:0] r_s1_length;
    logic       r_s1_rd_mem;
    logic       r_s1_rd_len;

    logic [7:0] r_store [STORE_DEPTH];
    logic [7:0] r_rdata;

    logic          accept;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    sum_add;
    logic [7:0]    count_inc;

    assign o_stall  = r_s1_valid && i_q_full;
    assign accept   = i_valid && !o_stall;
    assign o_q_push = r_s1_valid && !i_q_full;

    assign sum_add   = r_sum + i_rx_byte;
    assign count_inc = r_count + 8'd1;
    assign wr_addr   = count_inc[AW-1:0];
    assign rd_addr   = i_read_index[AW-1:0];
    assign wr_en     = accept && (i_mode == MODE_BYTE) && (r_phase == PAYLOAD);
    assign rd_en     = accept && (i_mode == MODE_READ) && (i_read_index != 8'd0);

    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_count  = r_count;
        n_ready  = r_ready;
        n_length = r_length;
        case (i_mode)
            MODE_BYTE: begin
                n_sum = sum_add;
                case (r_phase)
                    HUNT: begin
                        n_sum   = i_rx_byte;
                        n_phase = (i_rx_byte == HEADER_CHAR) ? LEN : HUNT;
                    end
                    LEN: begin
                        n_length = i_rx_byte;
                        n_count  = 8'd0;
                        n_phase  = PAYLOAD;
                    end
                    PAYLOAD: begin
                        n_count = count_inc[7:0];
                        if (count_inc[7:0] >= r_length) begin
                            n_phase = TRAILER;
                        end
                    end
                    TRAILER: begin
                        if (i_rx_byte != TRAILER_CHAR) begin
                            n_sum   = i_rx_byte;
                            n_phase = (i_rx_byte == HEADER_CHAR) ? LEN : HUNT;
                        end else begin
                            n_phase = CHECK;
                        end
                    end
                    CHECK: begin
                        if (sum_add != 8'd0) begin
                            n_sum   = i_rx_byte;
                            n_phase = (i_rx_byte == HEADER_CHAR) ? LEN : HUNT;
                        end else begin
                            n_ready = 1'b1;
                            n_phase = HELD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            MODE_RELEASE: begin
                n_ready = 1'b0;
                n_count = 8'd0;
                n_phase = HUNT;
                n_sum   = 8'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= HUNT;
            r_sum      <= 8'd0;
            r_count    <= 8'd0;
            r_ready    <= 1'b0;
            r_length   <= 8'd0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_sum      <= n_sum;
                r_count    <= n_count;
                r_ready    <= n_ready;
                r_length   <= n_length;
                r_s1_valid <= 1'b1;
            end else if (o_q_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ready  <= n_ready;
            r_s1_length <= n_length;
            r_s1_rd_mem <= (i_mode == MODE_READ) && (i_read_index != 8'd0);
            r_s1_rd_len <= (i_mode == MODE_READ) && (i_read_index == 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= i_rx_byte;
        end
        if (rd_en) begin
            r_rdata <= r_store[rd_addr];
        end
    end

    always_comb begin
        o_q_data.frame_ready  = r_s1_ready;
        o_q_data.frame_length = r_s1_length;
        if (r_s1_rd_mem) begin
            o_q_data.read_byte = r_rdata;
        end else if (r_s1_rd_len) begin
            o_q_data.read_byte = r_s1_length;
        end else begin
            o_q_data.read_byte = 8'd0;
        end
    end

`ifndef SYNTHESIS
    a_ready_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_phase == HELD))
        else $error("ready flag set outside held phase");

    a_no_len_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr != '0))
        else $error("payload write hit the length entry");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_s1_valid && $stable(o_q_data)))
        else $error("stage result changed while stalled");
`endif

endmodule

>>> design/ufr_queue.sv
// Short result queue between the parser front end and the output stage.
module ufr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ufr_pkg::t_result i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output ufr_pkg::t_result o_data
);
    import ufr_pkg::*;

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> design/ufr_back.sv
// Output stage: registered result transaction toward the downstream receiver.
module ufr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  ufr_pkg::t_result i_q_data,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_frame_ready,
    output logic [7:0]       o_frame_length,
    output logic [7:0]       o_read_byte
);
    import ufr_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_q_pop        = i_q_valid && (!r_valid || !i_stall);
    assign o_valid        = r_valid;
    assign o_frame_ready  = r_data.frame_ready;
    assign o_frame_length = r_data.frame_length;
    assign o_read_byte    = r_data.read_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data <= i_q_data;
        end
    end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the UART frame receiver: directed table, random frames, scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ufr_pkg::*;

    localparam logic [1:0] MODE_IDLE = 2'd3;

    localparam int FAULT_NONE    = 0;
    localparam int FAULT_TRAILER = 1;
    localparam int FAULT_SUM     = 2;
    localparam int FAULT_CUT     = 3;

    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 680;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int PRINT_LIMIT    = 200;

    localparam t_result NOTHING  = '0;
    localparam t_result HELD_RES = '{frame_ready: 1'b1, frame_length: 8'h00, read_byte: 8'h00};
    localparam t_result HELD_FF  = '{frame_ready: 1'b1, frame_length: 8'h00, read_byte: 8'hFF};

    typedef enum logic [2:0] {
        PH_HUNT, PH_LENGTH, PH_PAYLOAD, PH_TRAILER, PH_CHECKSUM, PH_HELD
    } t_phase;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] rx;
        logic [7:0] idx;
        bit         typed;
        t_result    want;
    } t_row;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [1:0] i_mode       = MODE_BYTE;
    logic [7:0] i_rx_byte    = 8'h00;
    logic [7:0] i_read_index = 8'h00;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_frame_ready;
    logic [7:0] o_frame_length;
    logic [7:0] o_read_byte;

    // receiver model state
    t_phase     rx_phase = PH_HUNT;
    logic [7:0] rx_sum   = 8'h00;
    logic [7:0] rx_count = 8'h00;
    logic       rx_ready = 1'b0;
    logic [7:0] frame_mem [256] = '{default: 8'h00};
    int         hi_stored = -1;

    t_result    pending_results [$];
    int         mismatches = 0;
    int         sent_count = 0;
    bit         calm       = 1'b0;
    bit         long_hold  = 1'b0;

    t_row directed_rows [DIRECTED_ROWS] = '{
        '{MODE_IDLE,    8'h00,        8'h00, 1'b1, NOTHING},
        '{MODE_RELEASE, 8'h00,        8'h00, 1'b1, NOTHING},
        '{MODE_BYTE,    8'h00,        8'hFF, 1'b1, NOTHING},
        '{MODE_BYTE,    8'hFF,        8'h00, 1'b1, NOTHING},
        '{MODE_BYTE,    HEADER_CHAR,  8'h00, 1'b1, NOTHING},
        '{MODE_BYTE,    8'h00,        8'h00, 1'b1, NOTHING},   // zero length
        '{MODE_BYTE,    8'hFF,        8'h00, 1'b1, NOTHING},   // still takes one byte
        '{MODE_BYTE,    TRAILER_CHAR, 8'h00, 1'b1, NOTHING},
        '{MODE_BYTE,    8'hBA,        8'h00, 1'b1, HELD_RES},
        '{MODE_BYTE,    HEADER_CHAR,  8'h00, 1'b1, HELD_RES},  // ignored while held
        '{MODE_READ,    8'h00,        8'h00, 1'b1, HELD_RES},
        '{MODE_READ,    8'h00,        8'h01, 1'b1, HELD_FF},
        '{MODE_RELEASE, 8'h00,        8'h00, 1'b1, NOTHING},
        '{MODE_BYTE,    HEADER_CHAR,  8'h00, 1'b0, NOTHING},
        '{MODE_BYTE,    8'h01,        8'h00, 1'b0, NOTHING},
        '{MODE_BYTE,    8'h10,        8'h00, 1'b0, NOTHING},
        '{MODE_BYTE,    HEADER_CHAR,  8'h00, 1'b0, NOTHING},   // bad trailer, new header
        '{MODE_BYTE,    8'h02,        8'h00, 1'b0, NOTHING},
        '{MODE_BYTE,    8'h00,        8'h00, 1'b0, NOTHING},
        '{MODE_BYTE,    8'h80,        8'h00, 1'b0, NOTHING},
        '{MODE_BYTE,    TRAILER_CHAR, 8'h00, 1'b0, NOTHING},
        '{MODE_BYTE,    8'h00,        8'h00, 1'b0, NOTHING},   // bad sum
        '{MODE_READ,    8'h00,        8'h02, 1'b0, NOTHING},
        '{MODE_IDLE,    8'h00,        8'h00, 1'b0, NOTHING},
        '{MODE_READ,    8'hFF,        8'h00, 1'b0, NOTHING}
    };

    uart_frame_receiver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_rx_byte      (i_rx_byte),
        .i_read_index   (i_read_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_ready  (o_frame_ready),
        .o_frame_length (o_frame_length),
        .o_read_byte    (o_read_byte)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void restart_on(input logic [7:0] b);
        rx_sum   = b;
        rx_phase = (b == HEADER_CHAR) ? PH_LENGTH : PH_HUNT;
    endfunction

    function automatic t_result advance_receiver(input logic [1:0] mode, input logic [7:0] b,
                                                 input logic [7:0] idx);
        t_result    res;
        logic [7:0] slot;
        logic [7:0] rd;
        rd = 8'h00;
        case (mode)
            MODE_BYTE: begin
                rx_sum = rx_sum + b;
                case (rx_phase)
                    PH_HUNT: restart_on(b);
                    PH_LENGTH: begin
                        frame_mem[0] = b;
                        rx_count     = 8'h00;
                        rx_phase     = PH_PAYLOAD;
                        if (hi_stored < 0) hi_stored = 0;
                    end
                    PH_PAYLOAD: begin
                        slot = rx_count + 8'd1;
                        frame_mem[slot] = b;
                        if (int'(slot) > hi_stored) hi_stored = int'(slot);
                        rx_count = rx_count + 8'd1;
                        if (rx_count >= frame_mem[0]) rx_phase = PH_TRAILER;
                    end
                    PH_TRAILER: begin
                        if (b != TRAILER_CHAR) restart_on(b);
                        else rx_phase = PH_CHECKSUM;
                    end
                    PH_CHECKSUM: begin
                        if (rx_sum != 8'h00) begin
                            restart_on(b);
                        end else begin
                            rx_ready = 1'b1;
                            rx_phase = PH_HELD;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_RELEASE: begin
                rx_ready = 1'b0;
                rx_count = 8'h00;
                rx_phase = PH_HUNT;
                rx_sum   = 8'h00;
            end
            MODE_READ: rd = frame_mem[idx];
            default: ;
        endcase
        res.frame_ready  = rx_ready;
        res.frame_length = frame_mem[0];
        res.read_byte    = rd;
        return res;
    endfunction

    function automatic logic [7:0] line_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return HEADER_CHAR;
            3: return TRAILER_CHAR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_transaction(input logic [1:0] mode, input logic [7:0] rx,
                                    input logic [7:0] idx, input bit typed, input t_result want);
        t_result res;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_rx_byte    <= rx;
        i_read_index <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = advance_receiver(mode, rx, idx);
        pending_results.push_back(typed ? want : res);
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_transaction(MODE_BYTE, b, 8'($urandom_range(0, 255)), 1'b0, NOTHING);
    endtask

    task automatic send_control(input logic [1:0] mode);
        send_transaction(mode, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         1'b0, NOTHING);
    endtask

    task automatic read_entry(input int idx);
        send_transaction(MODE_READ, 8'($urandom_range(0, 255)), 8'(idx), 1'b0, NOTHING);
    endtask

    // only entries written since reset are read
    task automatic read_stored();
        case ($urandom_range(0, 3))
            0: read_entry(0);
            1: read_entry(hi_stored);
            default: read_entry($urandom_range(0, hi_stored));
        endcase
    endtask

    task automatic send_frame(input int len, input int fault);
        logic [7:0] sum;
        logic [7:0] b;
        int         n;
        n   = (len == 0) ? 1 : len;
        sum = HEADER_CHAR + 8'(len);
        send_byte(HEADER_CHAR);
        send_byte(8'(len));
        for (int i = 0; i < n; i++) begin
            if (fault == FAULT_CUT && i == n / 2) return;
            b = line_byte();
            sum = sum + b;
            send_byte(b);
        end
        b = TRAILER_CHAR;
        if (fault == FAULT_TRAILER) begin
            b = 8'($urandom_range(0, 255));
            if (b == TRAILER_CHAR) b = HEADER_CHAR;
        end
        sum = sum + b;
        send_byte(b);
        b = 8'h00 - sum;
        if (fault == FAULT_SUM) b = b + 8'($urandom_range(1, 255));
        send_byte(b);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic compare_result();
        t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result transaction with nothing pending");
            return;
        end
        want = pending_results.pop_front();
        if (o_frame_ready !== want.frame_ready)
            report_mismatch($sformatf("frame_ready got %0b want %0b",
                                      o_frame_ready, want.frame_ready));
        if (o_frame_length !== want.frame_length)
            report_mismatch($sformatf("frame_length got %02h want %02h",
                                      o_frame_length, want.frame_length));
        if (o_read_byte !== want.read_byte)
            report_mismatch($sformatf("read_byte got %02h want %02h",
                                      o_read_byte, want.read_byte));
    endtask

    // result side: check, then choose the next stall
    initial begin : result_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) compare_result();
            if (long_hold) begin
                long_hold  = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        bit pressed;
        bit drained;
        bit big_done;
        int pick;
        int len;
        int fault;
        pressed  = 1'b0;
        drained  = 1'b0;
        big_done = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_transaction(directed_rows[i].mode, directed_rows[i].rx, directed_rows[i].idx,
                             directed_rows[i].typed, directed_rows[i].want);

        while (sent_count < DIRECTED_ROWS + RANDOM_ITEMS) begin
            calm = (sent_count >= 230 && sent_count < 290) || sent_count >= 620;
            if (!pressed && sent_count >= 150) begin
                pressed   = 1'b1;
                long_hold = 1'b1;
                send_control(MODE_RELEASE);
                send_frame(6, FAULT_NONE);
            end else if (!drained && sent_count >= 450) begin
                drained = 1'b1;
                wait_for_results();
            end else if (!big_done && sent_count >= 320) begin
                big_done = 1'b1;
                send_control(MODE_RELEASE);
                send_frame(255, FAULT_NONE);
                read_entry(255);
                read_entry(254);
                read_entry(0);
                send_control(MODE_RELEASE);
            end else if (rx_ready) begin
                repeat ($urandom_range(0, 3)) read_stored();
                if ($urandom_range(0, 3) == 0) send_byte(line_byte());
                if ($urandom_range(0, 4) != 0) send_control(MODE_RELEASE);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    len   = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
                                                          : $urandom_range(7, 24);
                    fault = $urandom_range(0, 99);
                    if (fault < 75)      send_frame(len, FAULT_NONE);
                    else if (fault < 83) send_frame(len, FAULT_TRAILER);
                    else if (fault < 91) send_frame(len, FAULT_SUM);
                    else                 send_frame(len, FAULT_CUT);
                end else if (pick < 72) begin
                    if (hi_stored >= 0) repeat ($urandom_range(1, 3)) read_stored();
                end else if (pick < 80) begin
                    send_control(MODE_RELEASE);
                end else if (pick < 95) begin
                    repeat ($urandom_range(1, 4)) send_byte(line_byte());
                end else begin
                    send_control(MODE_IDLE);
                end
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
